[src/gdrh_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package gdrh_pkg;

    // Default sizes of the tables.
    localparam int REGION_COUNT_DEF = 4096;
    localparam int COUNT_BITS_DEF   = 32;

    // Fixed field widths of the stream beats.
    localparam int QUERY_W  = 31;
    localparam int REGION_W = 12;
    localparam int OUT_W    = 32;
    localparam int IN_DATA_W = 48;
    localparam int IN_USER_W = 3;

    // Operation codes carried in the low bits of the input tuser.
    typedef enum logic [1:0] {
        OP_HIT   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    // Control sequencer states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

endpackage

`default_nettype wire

[src/grouped_dedup_region_histogram.sv]
`timescale 1ns / 1ps
`default_nettype none

// Region hit histogram with optional per-pair deduplication. Each input beat
// carries an operation in tuser: a hit, a read of one count, or a clear of
// all tables. A hit or a read first does the synchronous read of the count
// and tag memories, then modifies and writes the row back and loads the
// result register; the block takes no new beat until it is done with the
// last one. A read whose result cannot be loaded because the previous result
// is still waiting holds the block until the output register frees. While a
// clear, or the clearing pass after reset, sweeps both memories one row per
// cycle, no input beat is accepted; configuration writes are accepted at any
// time. With same_chromosome set, every hit counts under the anchor flag and
// each region is counted at most once per run of equal pair indices. Counts
// saturate at 2^COUNT_BITS - 1.
module grouped_dedup_region_histogram #(
    parameter int REGION_COUNT = gdrh_pkg::REGION_COUNT_DEF,
    parameter int COUNT_BITS   = gdrh_pkg::COUNT_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Configuration write channel: bit 0 is same_chromosome.
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic                           i_cfg_data,
    // Input stream.
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // tdata: query_index [30:0], region_index [42:31], zero fill [47:43].
    input  wire logic [gdrh_pkg::IN_DATA_W-1:0] i_s_tdata,
    // tuser: op [1:0], is_anchor [2].
    input  wire logic [gdrh_pkg::IN_USER_W-1:0] i_s_tuser,
    // Output stream.
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // tdata: count [31:0].
    output logic      [gdrh_pkg::OUT_W-1:0]     o_m_tdata
);

    import gdrh_pkg::*;

    localparam int RIDX_W = $clog2(REGION_COUNT);
    localparam int ROW_W  = 2 * COUNT_BITS;
    localparam int TAG_W  = QUERY_W + 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Sequencer and item registers.
    t_state                r_state, n_state;
    logic [RIDX_W-1:0]     r_clr_addr, n_clr_addr;
    logic [1:0]            r_op;
    logic [QUERY_W-1:0]    r_query;
    logic [REGION_W-1:0]   r_region;
    logic                  r_anchor;
    logic                  r_same_chrom;
    logic                  r_out_valid, n_out_valid;
    logic [OUT_W-1:0]      r_out_count, n_out_count;

    // Memory ports.
    logic                  cnt_we, tag_we, mem_re;
    logic [RIDX_W-1:0]     mem_waddr, mem_raddr;
    logic [ROW_W-1:0]      cnt_wdata, cnt_rdata;
    logic [TAG_W-1:0]      tag_wdata, tag_rdata;

    // Decoded item.
    logic                  s_accept;
    logic                  in_range;
    logic [RIDX_W-1:0]     item_addr;
    logic [31:0]           region_ext;
    logic [COUNT_BITS-1:0] cnt_sel, cnt_bump;
    logic                  tag_hit;
    logic                  out_free;
    logic                  clr_last;

    assign s_accept   = i_s_tvalid && o_s_tready;
    assign region_ext = 32'(r_region);
    assign in_range   = region_ext < 32'(REGION_COUNT);
    assign item_addr  = region_ext[RIDX_W-1:0];
    assign out_free   = !r_out_valid || i_m_tready;
    assign clr_last   = r_clr_addr == RIDX_W'(REGION_COUNT - 1);
    assign tag_hit    = tag_rdata[TAG_W-1] && (tag_rdata[QUERY_W-1:0] == r_query);

    // Count selected by the effective flag, and its saturating increment.
    always_comb begin
        if (r_same_chrom || r_anchor) begin
            cnt_sel = cnt_rdata[ROW_W-1:COUNT_BITS];
        end else begin
            cnt_sel = cnt_rdata[COUNT_BITS-1:0];
        end
        cnt_bump = (cnt_sel == COUNT_MAX) ? cnt_sel : cnt_sel + 1'b1;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (r_op)
                    OP_CLEAR: n_state = ST_CLEAR;
                    OP_READ:  n_state = out_free ? ST_IDLE : ST_EXEC;
                    default:  n_state = ST_IDLE;
                endcase
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // Memory controls and result register.
    always_comb begin
        o_s_tready  = r_state == ST_IDLE;
        mem_re      = s_accept;
        {mem_raddr, mem_waddr} = '0;
        mem_raddr   = 32'(i_s_tdata[QUERY_W +: REGION_W]) < 32'(REGION_COUNT)
                    ? RIDX_W'(32'(i_s_tdata[QUERY_W +: REGION_W])) : '0;
        mem_waddr   = item_addr;
        cnt_we      = 1'b0;
        tag_we      = 1'b0;
        cnt_wdata   = cnt_rdata;
        tag_wdata   = {1'b1, r_query};
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_count = r_out_count;
        unique case (r_state)
            ST_CLEAR: begin
                mem_waddr  = r_clr_addr;
                cnt_we     = 1'b1;
                tag_we     = 1'b1;
                cnt_wdata  = '0;
                tag_wdata  = '0;
                n_clr_addr = clr_last ? '0 : r_clr_addr + 1'b1;
            end
            ST_IDLE: begin
            end
            ST_EXEC: begin
                case (r_op)
                    OP_HIT: begin
                        if (in_range) begin
                            if (r_same_chrom) begin
                                if (!tag_hit) begin
                                    tag_we = 1'b1;
                                    cnt_we = 1'b1;
                                    cnt_wdata[ROW_W-1:COUNT_BITS] = cnt_bump;
                                end
                            end else begin
                                cnt_we = 1'b1;
                                if (r_anchor) begin
                                    cnt_wdata[ROW_W-1:COUNT_BITS] = cnt_bump;
                                end else begin
                                    cnt_wdata[COUNT_BITS-1:0] = cnt_bump;
                                end
                            end
                        end
                    end
                    OP_READ: begin
                        if (out_free) begin
                            n_out_valid = 1'b1;
                            if (!in_range) begin
                                n_out_count = '0;
                            end else if (r_anchor) begin
                                n_out_count = OUT_W'(cnt_rdata[ROW_W-1:COUNT_BITS]);
                            end else begin
                                n_out_count = OUT_W'(cnt_rdata[COUNT_BITS-1:0]);
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_out_valid  <= 1'b0;
            r_same_chrom <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_same_chrom <= i_cfg_data;
            end
        end
    end

    // Item and result payload.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_op     <= i_s_tuser[1:0];
            r_anchor <= i_s_tuser[2];
            r_query  <= i_s_tdata[QUERY_W-1:0];
            r_region <= i_s_tdata[QUERY_W +: REGION_W];
        end
        r_out_count <= n_out_count;
    end

    // Count rows: flag 0 in the low half, flag 1 in the high half.
    gdrh_ram #(
        .WIDTH (ROW_W),
        .DEPTH (REGION_COUNT)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (mem_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (cnt_rdata)
    );

    // Last pair tags: valid bit on top of the pair index.
    gdrh_ram #(
        .WIDTH (TAG_W),
        .DEPTH (REGION_COUNT)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (mem_waddr),
        .i_wdata (tag_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (tag_rdata)
    );

    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_count;

endmodule

`default_nettype wire

[src/gdrh_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module gdrh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Single write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
